FILE: design/vtat_pkg.sv
`default_nettype none

package vtat_pkg;

    // item action codes
    localparam logic [1:0] ACT_SET   = 2'd0;
    localparam logic [1:0] ACT_TRY   = 2'd1;
    localparam logic [1:0] ACT_TRACE = 2'd2;

    // fixed field widths
    localparam int COST_W   = 16;
    localparam int BRANCH_W = 8;
    localparam int POS_W    = 5;

    localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

    // one word of the path cost memory
    typedef struct packed {
        logic              en;
        logic [COST_W-1:0] cost;
    } cost_word_t;

endpackage

`default_nettype wire

FILE: design/viterbi_trellis_acs_traceback_top.sv
`default_nettype none

// Viterbi trellis with add-compare-select node updates and survivor traceback.
// Input channel: an item is taken at a rising edge with start high and busy
// low. action selects set node, try set (compare-select) or traceback; other
// codes and columns beyond STAGES are taken and dropped without effect.
// Result channel: result_valid marks one cycle with out_bit, bit_position and
// last_bit; the receiver cannot stall, results are never held back.
// Node costs and enabled marks sit in one memory, parent links and bits in a
// second; both have registered reads.
// Set and try set: the accept edge reads the parent cost and the node word,
// the next cycle adds, compares and writes back. busy holds off the next
// item until the write is done, so no forwarding is needed.
// Traceback scans the last column row by row for the cheapest row, then walks
// the parent links column by column, each link read feeding the next read
// address. Results leave from an output register, one per cycle, highest
// position first.
// After reset the cost memory is cleared with busy high, one entry a cycle,
// all 2**MEMORY_BITS * (STAGES+1) entries (264 by default).
module viterbi_trellis_acs_traceback_top #(
    parameter int MEMORY_BITS = 3,
    parameter int STAGES      = 32
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  start,
    output logic                                       busy,
    input  wire logic [1:0]                            action,
    input  wire logic [MEMORY_BITS-1:0]                state_row,
    input  wire logic [$clog2(STAGES+1)-1:0]           stage_col,
    input  wire logic                                  decoded_bit,
    input  wire logic [MEMORY_BITS-1:0]                parent_row,
    input  wire logic [vtat_pkg::BRANCH_W-1:0]         branch_cost,
    output logic                                       result_valid,
    output logic                                       out_bit,
    output logic [vtat_pkg::POS_W-1:0]                 bit_position,
    output logic                                       last_bit
);

    localparam int ROWS   = 1 << MEMORY_BITS;
    localparam int COLS   = STAGES + 1;
    localparam int NODES  = ROWS * COLS;
    localparam int ADDR_W = $clog2(NODES);
    localparam int COL_W  = $clog2(STAGES + 1);
    localparam int MB     = MEMORY_BITS;
    localparam int CW     = vtat_pkg::COST_W;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_UPD   = 3'd2;
    localparam logic [2:0] ST_SCAN  = 3'd3;
    localparam logic [2:0] ST_WALK  = 3'd4;

    localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(STAGES);
    localparam logic [MB-1:0]     LAST_ROW  = MB'(ROWS - 1);
    localparam logic [ADDR_W-1:0] LAST_NODE = ADDR_W'(NODES - 1);

    // node address: row * COLS + col
    function automatic logic [ADDR_W-1:0] node_addr(input logic [MB-1:0] r,
                                                    input logic [COL_W-1:0] c);
        logic [ADDR_W-1:0] base;
        base = ADDR_W'(ADDR_W'(r) * ADDR_W'(COLS));
        return base + ADDR_W'(c);
    endfunction

    // memories
    vtat_pkg::cost_word_t cost_mem [NODES];
    logic [MB:0]          link_mem [NODES];

    logic [2:0]                     state_reg;
    logic [ADDR_W-1:0]              clear_cnt_reg;
    logic [1:0]                     act_reg;
    logic [MB-1:0]                  row_reg;
    logic [COL_W-1:0]               col_reg;
    logic                           bit_reg;
    logic [MB-1:0]                  par_reg;
    logic [vtat_pkg::BRANCH_W-1:0]  branch_reg;
    logic [MB-1:0]                  scan_cnt_reg;
    logic [MB-1:0]                  best_row_reg;
    logic [CW-1:0]                  best_cost_reg;
    vtat_pkg::cost_word_t           cost_a_reg;
    vtat_pkg::cost_word_t           cost_b_reg;
    logic [MB:0]                    link_rd_reg;
    logic                           result_valid_reg;
    logic                           out_bit_reg;
    logic [vtat_pkg::POS_W-1:0]     pos_reg;
    logic                           last_reg;

    logic                           accept;
    logic                           node_item;
    logic [COL_W-1:0]               prev_col;
    logic [ADDR_W-1:0]              cost_raddr_a;
    logic [ADDR_W-1:0]              cost_raddr_b;
    logic [ADDR_W-1:0]              link_raddr;
    logic [ADDR_W-1:0]              upd_addr;
    logic [CW:0]                    upd_sum;
    logic [CW-1:0]                  upd_cost;
    logic                           upd_write;
    logic                           cost_we;
    logic [ADDR_W-1:0]              cost_waddr;
    vtat_pkg::cost_word_t           cost_wdata;
    logic                           scan_take;
    logic [MB-1:0]                  win_row;

    assign busy         = (state_reg != ST_IDLE);
    assign accept       = start && !busy;
    assign result_valid = result_valid_reg;
    assign out_bit      = out_bit_reg;
    assign bit_position = pos_reg;
    assign last_bit     = last_reg;

    // input decode
    assign node_item = ((action == vtat_pkg::ACT_SET) || (action == vtat_pkg::ACT_TRY))
                       && (stage_col <= LAST_COL);
    assign prev_col  = (stage_col == '0) ? '0 : stage_col - COL_W'(1);

    // cost read addresses: parent cost on port a, node or scan row on port b
    always_comb
    begin
        cost_raddr_a = node_addr(parent_row, prev_col);
        if (state_reg == ST_SCAN)
        begin
            cost_raddr_b = node_addr(scan_cnt_reg + MB'(1), LAST_COL);
        end
        else if (action == vtat_pkg::ACT_TRACE)
        begin
            cost_raddr_b = node_addr('0, LAST_COL);
        end
        else
        begin
            cost_raddr_b = node_addr(state_row, stage_col);
        end
    end

    // add-compare-select
    always_comb
    begin
        upd_addr = node_addr(row_reg, col_reg);
        upd_sum  = {1'b0, cost_a_reg.cost} + (CW + 1)'(branch_reg);
        if (col_reg == '0)
        begin
            upd_cost = CW'(branch_reg);
        end
        else if (upd_sum[CW])
        begin
            upd_cost = vtat_pkg::COST_MAX;
        end
        else
        begin
            upd_cost = upd_sum[CW-1:0];
        end
        upd_write = (act_reg == vtat_pkg::ACT_SET) || (col_reg == '0)
                    || !cost_b_reg.en || (upd_cost < cost_b_reg.cost);
    end

    // minimum search over the last column
    assign scan_take = (scan_cnt_reg == '0) || (cost_b_reg.cost < best_cost_reg);
    assign win_row   = scan_take ? scan_cnt_reg : best_row_reg;

    // link read address: winner row at the end of the scan, else next parent
    always_comb
    begin
        if (state_reg == ST_SCAN)
        begin
            link_raddr = node_addr(win_row, LAST_COL);
        end
        else
        begin
            link_raddr = node_addr(link_rd_reg[MB-1:0], col_reg - COL_W'(1));
        end
    end

    // cost memory write: clearing pass or node update
    always_comb
    begin
        cost_we    = 1'b0;
        cost_waddr = upd_addr;
        cost_wdata = '{en: 1'b1, cost: upd_cost};
        if (state_reg == ST_CLEAR)
        begin
            cost_we    = 1'b1;
            cost_waddr = clear_cnt_reg;
            cost_wdata = '{en: 1'b0, cost: '0};
        end
        else if (state_reg == ST_UPD)
        begin
            cost_we = upd_write;
        end
    end

    // cost memory
    always_ff @(posedge clk)
    begin
        if (cost_we)
        begin
            cost_mem[cost_waddr] <= cost_wdata;
        end
        cost_a_reg <= cost_mem[cost_raddr_a];
        cost_b_reg <= cost_mem[cost_raddr_b];
    end

    // link memory
    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_UPD) && upd_write)
        begin
            link_mem[upd_addr] <= {bit_reg, par_reg};
        end
        link_rd_reg <= link_mem[link_raddr];
    end

    // item fields and traceback payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg    <= action;
            row_reg    <= state_row;
            col_reg    <= stage_col;
            bit_reg    <= decoded_bit;
            par_reg    <= parent_row;
            branch_reg <= branch_cost;
        end
        else if (state_reg == ST_SCAN)
        begin
            col_reg <= LAST_COL;
        end
        else if (state_reg == ST_WALK)
        begin
            col_reg <= col_reg - COL_W'(1);
        end
        if (state_reg == ST_SCAN)
        begin
            best_row_reg  <= win_row;
            best_cost_reg <= scan_take ? cost_b_reg.cost : best_cost_reg;
        end
        out_bit_reg <= link_rd_reg[MB];
        pos_reg     <= vtat_pkg::POS_W'(col_reg - COL_W'(1));
        last_reg    <= (col_reg == COL_W'(1));
    end

    // control sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            clear_cnt_reg    <= '0;
            scan_cnt_reg     <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= (state_reg == ST_WALK);
            unique case (state_reg)
                ST_CLEAR:
                begin
                    clear_cnt_reg <= clear_cnt_reg + ADDR_W'(1);
                    if (clear_cnt_reg == LAST_NODE)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    scan_cnt_reg <= '0;
                    if (accept && node_item)
                    begin
                        state_reg <= ST_UPD;
                    end
                    else if (accept && (action == vtat_pkg::ACT_TRACE))
                    begin
                        state_reg <= ST_SCAN;
                    end
                end
                ST_UPD:
                begin
                    state_reg <= ST_IDLE;
                end
                ST_SCAN:
                begin
                    scan_cnt_reg <= scan_cnt_reg + MB'(1);
                    if (scan_cnt_reg == LAST_ROW)
                    begin
                        state_reg <= ST_WALK;
                    end
                end
                ST_WALK:
                begin
                    if (col_reg == COL_W'(1))
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire
